// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on a clock with active-low reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check built on the plain one
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/mexp_pkg.sv =====
// shared constants and types of the modular exponentiation block
package mexp_pkg;

  localparam int unsigned MOD_WIDTH = 63;
  localparam int unsigned CFG_WIDTH = 63;
  localparam int unsigned IN_WIDTH  = 64;
  localparam int unsigned OUT_WIDTH = 63;
  localparam int unsigned CNT_WIDTH = $clog2(IN_WIDTH);
  localparam int unsigned IDX_WIDTH = 2;

  typedef logic [MOD_WIDTH-1:0] word_t;
  typedef logic [IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// modular exponentiation core: cipher_block ^ exponent mod modulus
// One block at a time. After the input transfer the block first reduces
// cipher_block modulo the modulus, one input bit per cycle, then walks the
// exponent from its least significant bit upward. Each set exponent bit costs
// one modular multiply into the accumulator, and every exponent bit up to the
// highest set one costs one modular square of the base. A multiply runs on a
// single add-and-double unit that consumes one multiplier bit per cycle; each
// step also passes through the sequencer state. A modulus of one or zero goes
// straight to the done state and yields 0. The input side stays stalled until
// the result is in the output register; the next block is taken while that
// result waits.
module modular_exponentiation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  mexp_pkg::cfg_idx_t              cfg_index_i,
  input  logic [mexp_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mexp_pkg::IN_WIDTH-1:0]   cipher_block_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mexp_pkg::OUT_WIDTH-1:0]  plain_block_o
);

  localparam int unsigned W = mexp_pkg::MOD_WIDTH;

  mexp_pkg::state_e state_q, state_d;

  mexp_pkg::word_t modulus_q, exponent_q;
  mexp_pkg::word_t base_q, base_d;
  mexp_pkg::word_t acc_q, acc_d;
  mexp_pkg::word_t exp_q, exp_d;
  mexp_pkg::word_t addend_q, addend_d;
  mexp_pkg::word_t mulr_q, mulr_d;
  mexp_pkg::word_t prod_q, prod_d;
  mexp_pkg::word_t res_q, res_d;
  logic [mexp_pkg::IN_WIDTH-1:0]  shift_q, shift_d;
  logic [mexp_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic phase_q, phase_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer, out_load, mod_small;
  logic [W:0] red_sum;

  // (a + b) mod n for a, b below n
  function automatic mexp_pkg::word_t mod_add(mexp_pkg::word_t a, mexp_pkg::word_t b,
                                              mexp_pkg::word_t n);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[W-1:0];
  endfunction

  assign mod_small = (modulus_q <= W'(1));
  assign in_xfer   = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (cnt_q == mexp_pkg::CNT_WIDTH'(mexp_pkg::IN_WIDTH - 1)) begin
          state_d = mexp_pkg::ST_STEP;
        end
      end
      mexp_pkg::ST_STEP: begin
        if (exp_q == '0) begin
          state_d = mexp_pkg::ST_DONE;
        end else if (phase_q || exp_q[0]) begin
          state_d = mexp_pkg::ST_MUL;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mulr_q == '0) begin
          state_d = mexp_pkg::ST_STEP;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = mexp_pkg::ST_IDLE;
        end
      end
      default: state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != mexp_pkg::ST_IDLE);
    out_load   = (state_q == mexp_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // datapath
  always_comb begin
    base_d    = base_q;
    acc_d     = acc_q;
    exp_d     = exp_q;
    addend_d  = addend_q;
    mulr_d    = mulr_q;
    prod_d    = prod_q;
    res_d     = res_q;
    shift_d   = shift_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    red_sum   = {base_q, shift_q[mexp_pkg::IN_WIDTH-1]};
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          shift_d = cipher_block_i;
          cnt_d   = '0;
          base_d  = '0;
          acc_d   = mod_small ? '0 : W'(1);
          exp_d   = exponent_q;
          phase_d = 1'b0;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (red_sum >= {1'b0, modulus_q}) begin
          red_sum = red_sum - {1'b0, modulus_q};
        end
        base_d  = red_sum[W-1:0];
        shift_d = shift_q << 1;
        cnt_d   = cnt_q + 1'b1;
      end
      mexp_pkg::ST_STEP: begin
        if (exp_q != '0) begin
          if (phase_q) begin
            addend_d = base_q;
            mulr_d   = base_q;
            prod_d   = '0;
          end else if (exp_q[0]) begin
            addend_d = acc_q;
            mulr_d   = base_q;
            prod_d   = '0;
          end else begin
            phase_d = 1'b1;
          end
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mulr_q == '0) begin
          if (phase_q) begin
            base_d  = prod_q;
            exp_d   = exp_q >> 1;
            phase_d = 1'b0;
          end else begin
            acc_d   = prod_q;
            phase_d = 1'b1;
          end
        end else begin
          if (mulr_q[0]) begin
            prod_d = mod_add(prod_q, addend_q, modulus_q);
          end
          addend_d = mod_add(addend_q, addend_q, modulus_q);
          mulr_d   = mulr_q >> 1;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (out_load) begin
          res_d = acc_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      modulus_q   <= W'(1);
      exponent_q  <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      if (cfg_we_i && (cfg_index_i == mexp_pkg::REG_MODULUS)) begin
        modulus_q <= cfg_data_i[W-1:0];
      end
      if (cfg_we_i && (cfg_index_i == mexp_pkg::REG_EXPONENT)) begin
        exponent_q <= cfg_data_i[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    acc_q    <= acc_d;
    addend_q <= addend_d;
    mulr_q   <= mulr_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
    shift_q  <= shift_d;
  end

  assign out_valid_o   = out_valid_q;
  assign plain_block_o = mexp_pkg::OUT_WIDTH'(res_q);

endmodule

// ===== hdl/mexp_checker.sv =====
// port-level checks for the modular exponentiation core
`include "assert_macros.svh"

module mexp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  mexp_pkg::cfg_idx_t              cfg_index_i,
  input  logic [mexp_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [mexp_pkg::OUT_WIDTH-1:0]  plain_block_o
);

  mexp_pkg::word_t mod_q;
  logic [mexp_pkg::OUT_WIDTH-1:0] mod_ext;

  // mirror of the modulus register as seen on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mexp_pkg::MOD_WIDTH'(1);
    end else if (cfg_we_i && (cfg_index_i == mexp_pkg::REG_MODULUS)) begin
      mod_q <= cfg_data_i[mexp_pkg::MOD_WIDTH-1:0];
    end
  end

  assign mod_ext = mexp_pkg::OUT_WIDTH'(mod_q);

  `ASSERT_IMPL(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && !in_stall_o, ##1 in_stall_o, "core not busy after input transfer")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(plain_block_o)), "stalled result changed")
  `ASSERT_IMPL(a_result_range, clk_i, rst_ni, out_valid_o && (mod_q > mexp_pkg::MOD_WIDTH'(1)), plain_block_o < mod_ext, "result not below modulus")
  `ASSERT_IMPL(a_small_modulus, clk_i, rst_ni, out_valid_o && (mod_q <= mexp_pkg::MOD_WIDTH'(1)), plain_block_o == '0, "nonzero result for modulus below two")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .plain_block_o (plain_block_o)
);

// ===== tb/tb_modular_exponentiation.sv =====
// self-checking testbench for the modular exponentiation core
module tb_modular_exponentiation;

  typedef logic [mexp_pkg::IN_WIDTH-1:0] block_t;

  localparam int CLK_PERIOD = 20;
  localparam longint TIMEOUT_CYCLES = 5000000;
  localparam int RANDOM_PHASES = 10;
  localparam int BLOCKS_PER_PHASE = 10;
  localparam mexp_pkg::cfg_idx_t IDX_UNMAPPED =
    mexp_pkg::REG_EXPONENT + mexp_pkg::cfg_idx_t'(1);
  localparam mexp_pkg::cfg_idx_t IDX_UNMAPPED_TOP = '1;
  localparam mexp_pkg::word_t MODULUS_MAX = '1;
  localparam block_t BLOCK_ONES = '1;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  mexp_pkg::cfg_idx_t             cfg_index_i;
  logic [mexp_pkg::CFG_WIDTH-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  block_t                         cipher_block_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  mexp_pkg::word_t                plain_block_o;

  mexp_pkg::word_t key_modulus;
  mexp_pkg::word_t key_exponent;
  block_t          cipher_pending[$];
  mexp_pkg::word_t plain_expected[$];
  mexp_pkg::word_t plain_want;
  bit              cipher_taken;
  bit              idle_on;
  int              send_gap;
  int              stall_left;
  int              blocks_queued;
  int              blocks_sent;
  int              plains_checked;
  int              key_settings;
  int              errors;

  modular_exponentiation i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cipher_block_i(cipher_block_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .plain_block_o (plain_block_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic block_t mod_mul(input block_t x, input block_t y, input block_t n);
    block_t acc;
    block_t addend;
    acc = '0;
    addend = x % n;
    while (y != 0) begin
      if (y[0]) acc = (acc + addend) % n;
      addend = (addend + addend) % n;
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic mexp_pkg::word_t plain_of(input block_t cipher);
    block_t n;
    block_t base;
    block_t acc;
    block_t e;
    n = block_t'(key_modulus);
    if (n <= 1) return '0;
    acc = block_t'(1);
    base = cipher % n;
    e = block_t'(key_exponent);
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, base, n);
      base = mod_mul(base, base, n);
      e = e >> 1;
    end
    return mexp_pkg::word_t'(acc);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic note_error(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic write_reg(input mexp_pkg::cfg_idx_t idx,
                           input logic [mexp_pkg::CFG_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    if (idx == mexp_pkg::REG_MODULUS) key_modulus = mexp_pkg::word_t'(value);
    else if (idx == mexp_pkg::REG_EXPONENT) key_exponent = mexp_pkg::word_t'(value);
    @(posedge clk_i);
  endtask

  task automatic load_keys(input mexp_pkg::word_t n, input mexp_pkg::word_t d,
                           input bit stray);
    write_reg(mexp_pkg::REG_MODULUS, n);
    if (stray) write_reg($urandom_range(0, 1) ? IDX_UNMAPPED : IDX_UNMAPPED_TOP,
                         mexp_pkg::word_t'({$urandom, $urandom}));
    write_reg(mexp_pkg::REG_EXPONENT, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    key_settings++;
  endtask

  task automatic queue_block(input block_t cipher);
    cipher_pending.push_back(cipher);
    blocks_queued++;
  endtask

  task automatic drain();
    while (plains_checked < blocks_queued) @(negedge clk_i);
  endtask

  // result check first, then the input transfer of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (plain_expected.size() == 0) begin
          note_error($sformatf("result %h with nothing expected", plain_block_o));
        end else begin
          plain_want = plain_expected.pop_front();
          plains_checked++;
          if (plain_block_o !== plain_want)
            note_error($sformatf("plain_block got %h want %h (n=%h d=%h)",
                                 plain_block_o, plain_want, key_modulus, key_exponent));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        plain_expected.push_back(plain_of(cipher_block_i));
        cipher_taken = 1'b1;
        blocks_sent++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || cipher_taken) begin
      cipher_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cipher_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        cipher_block_i <= cipher_pending.pop_front();
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int              k;
    int              i;
    int              mod_bits;
    int              exp_bits;
    int              pick;
    mexp_pkg::word_t n;
    mexp_pkg::word_t d;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = mexp_pkg::REG_MODULUS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cipher_block_i = '0;
    out_stall_i = 1'b0;
    cipher_taken = 1'b0;
    idle_on = 1'b0;
    send_gap = 0;
    stall_left = 0;
    blocks_queued = 0;
    blocks_sent = 0;
    plains_checked = 0;
    key_settings = 0;
    errors = 0;
    key_modulus = mexp_pkg::word_t'(1);
    key_exponent = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // keys after reset: modulus one
    queue_block('0);
    queue_block(BLOCK_ONES);
    drain();

    // exponent zero gives one
    idle_on = 1'b1;
    load_keys(MODULUS_MAX, '0, 1'b1);
    queue_block('0);
    queue_block(BLOCK_ONES);
    queue_block(block_t'(1) << (mexp_pkg::IN_WIDTH - 1));
    drain();

    // modulus zero behaves like modulus one
    load_keys('0, MODULUS_MAX, 1'b0);
    queue_block({$urandom, $urandom});
    queue_block(BLOCK_ONES);
    drain();

    // widest modulus and exponent
    idle_on = 1'b0;
    load_keys(MODULUS_MAX, MODULUS_MAX, 1'b1);
    queue_block('0);
    queue_block(block_t'(1));
    queue_block(block_t'(2));
    queue_block(BLOCK_ONES);
    queue_block(block_t'(MODULUS_MAX));
    queue_block(block_t'(MODULUS_MAX) - 1);
    queue_block(block_t'(1) << (mexp_pkg::IN_WIDTH - 1));
    drain();

    idle_on = 1'b1;
    load_keys(mexp_pkg::word_t'(1), mexp_pkg::word_t'({$urandom, $urandom}), 1'b0);
    queue_block({$urandom, $urandom});
    drain();

    load_keys(mexp_pkg::word_t'(2), mexp_pkg::word_t'(1), 1'b0);
    queue_block(block_t'(3));
    queue_block(BLOCK_ONES);
    drain();

    // textbook key pair
    load_keys(mexp_pkg::word_t'(3233), mexp_pkg::word_t'(2753), 1'b0);
    queue_block(block_t'(2790));
    queue_block({$urandom, $urandom});
    drain();

    // random keys, mostly narrow, every fourth phase full width
    for (k = 0; k < RANDOM_PHASES; k++) begin
      idle_on = (k % 3) != 0;
      mod_bits = (k % 4 == 1) ? int'(mexp_pkg::MOD_WIDTH) : $urandom_range(2, 24);
      exp_bits = (k % 4 == 1) ? int'(mexp_pkg::MOD_WIDTH) : $urandom_range(1, 24);
      n = (mexp_pkg::word_t'({$urandom, $urandom})
           & ((mexp_pkg::word_t'(1) << mod_bits) - 1))
          | (mexp_pkg::word_t'(1) << (mod_bits - 1));
      d = mexp_pkg::word_t'({$urandom, $urandom})
          & ((mexp_pkg::word_t'(1) << exp_bits) - 1);
      load_keys(n, d, $urandom_range(0, 3) == 0);
      for (i = 0; i < BLOCKS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) queue_block({$urandom, $urandom});
        else if (pick < 7) queue_block(block_t'({$urandom, $urandom}) % block_t'(n));
        else if (pick == 7) queue_block(block_t'(n));
        else if (pick == 8) queue_block(block_t'(n) - 1);
        else queue_block(block_t'(n) * $urandom_range(2, 9) + $urandom_range(0, 3));
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (plain_expected.size() != 0)
      note_error($sformatf("%0d results never arrived", plain_expected.size()));
    $display("run covered %0d cipher blocks under %0d key settings", blocks_sent,
             key_settings);
    $display("%0d plain blocks checked, %0d mismatches", plains_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
